/* hdl/pointwise_conv_requant_lut_act_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pointwise conv / requant / LUT activation block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINTWISE_CONV_REQUANT_LUT_ACT_ASSERT_SVH
`define POINTWISE_CONV_REQUANT_LUT_ACT_ASSERT_SVH

// same-cycle implication
`define PCRLA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcrla: assertion failed");

// next-cycle implication
`define PCRLA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcrla: assertion failed");

`endif

/* hdl/pcrla_pkg.sv */
// ----------------------------------------------------------------------------
// pcrla_pkg
// Shared constants and types of the pointwise conv / requant / LUT block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrla_pkg;

  localparam int LANES_DEF   = 8;   // default lane count
  localparam int FIELD_LANES = 8;   // lanes carried by one 64-bit field
  localparam int LANE_W      = 8;
  localparam int LANES_W     = FIELD_LANES * LANE_W;
  localparam int BIAS_W      = 32;
  localparam int ACC_W       = 32;
  localparam int VAL_W       = 8;
  localparam int LUT_DEPTH   = 256;
  localparam int LUT_AW      = $clog2(LUT_DEPTH);
  localparam int SHIFT_W     = 5;

  localparam int MQ_DEPTH    = 4;   // front-to-back queue, power of two
  localparam int OQ_DEPTH    = 8;   // result queue, power of two
  localparam int OQ_CW       = $clog2(OQ_DEPTH + 1);

  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam logic [CFG_AW-3:0] REG_RQ_SHIFT = 1'b0;

  localparam logic CMD_LUT_WR = 1'b0;
  localparam logic CMD_ACC    = 1'b1;

  localparam int RQ_MAX = 127;
  localparam int RQ_MIN = -128;
  localparam logic [LUT_AW-1:0] LUT_OFFSET = 8'd128;

  typedef enum logic [1:0] {
    KIND_LUT_WR,
    KIND_ACC,
    KIND_ACC_LAST
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic                     first;
    logic [LANES_W-1:0]       act_lanes;
    logic [LANES_W-1:0]       wt_lanes;
    logic signed [BIAS_W-1:0] bias;
    logic [LUT_AW-1:0]        lut_index;
    logic signed [VAL_W-1:0]  lut_value;
  } mq_item_t;

  typedef struct packed {
    logic             full;
    logic [OQ_CW-1:0] count;
    logic             pop;    // a result left the queue this cycle
  } oq_stat_t;

endpackage

`default_nettype wire

/* hdl/pcrla_ram.sv */
// ----------------------------------------------------------------------------
// pcrla_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/pcrla_front.sv */
// ----------------------------------------------------------------------------
// pcrla_front
// Accepts requests, tags them as table write / accumulate / accumulate-last
// and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrla_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire logic                               in_cmd,
  input  wire logic [pcrla_pkg::LANES_W-1:0]      in_act_lanes,
  input  wire logic [pcrla_pkg::LANES_W-1:0]      in_wt_lanes,
  input  wire logic signed [pcrla_pkg::BIAS_W-1:0] in_bias,
  input  wire logic                               in_first,
  input  wire logic                               in_last,
  input  wire logic [pcrla_pkg::LUT_AW-1:0]       in_lut_index,
  input  wire logic signed [pcrla_pkg::VAL_W-1:0] in_lut_value,
  output logic                                    mq_valid,
  output pcrla_pkg::mq_item_t                     mq_item,
  input  wire logic                               mq_pop
);

  import pcrla_pkg::*;

  localparam int PW = $clog2(MQ_DEPTH);
  localparam int CW = $clog2(MQ_DEPTH + 1);

  mq_item_t        mem_r [MQ_DEPTH];
  mq_item_t        item_nxt;
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            push, pop;

  always_comb begin
    item_nxt.first     = in_first;
    item_nxt.act_lanes = in_act_lanes;
    item_nxt.wt_lanes  = in_wt_lanes;
    item_nxt.bias      = in_bias;
    item_nxt.lut_index = in_lut_index;
    item_nxt.lut_value = in_lut_value;
    if (in_cmd == CMD_LUT_WR) begin
      item_nxt.kind = KIND_LUT_WR;
    end else if (in_last) begin
      item_nxt.kind = KIND_ACC_LAST;
    end else begin
      item_nxt.kind = KIND_ACC;
    end
  end

  assign in_full  = (cnt_r == CW'(MQ_DEPTH));
  assign mq_valid = (cnt_r != '0);
  assign mq_item  = mem_r[rp_r];
  assign push     = in_push && !in_full;
  assign pop      = mq_pop && mq_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

/* hdl/pcrla_outq.sv */
// ----------------------------------------------------------------------------
// pcrla_outq
// Result queue feeding the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrla_outq (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  input  wire logic signed [pcrla_pkg::VAL_W-1:0]  push_value,
  input  wire logic signed [pcrla_pkg::VAL_W-1:0]  push_rq,
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output logic signed [pcrla_pkg::VAL_W-1:0]       out_value,
  output logic signed [pcrla_pkg::VAL_W-1:0]       out_requantized,
  output pcrla_pkg::oq_stat_t                      stat
);

  import pcrla_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] rq;
  } oq_entry_t;

  oq_entry_t          mem_r [OQ_DEPTH];
  logic [PW-1:0]      wp_r, rp_r;
  logic [OQ_CW-1:0]   cnt_r;
  logic               pop;

  assign out_empty       = (cnt_r == '0);
  assign pop             = out_pop && !out_empty;
  assign out_value       = mem_r[rp_r].value;
  assign out_requantized = mem_r[rp_r].rq;
  assign stat.full       = (cnt_r == OQ_CW'(OQ_DEPTH));
  assign stat.count      = cnt_r;
  assign stat.pop        = pop;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{value: push_value, rq: push_rq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + OQ_CW'(push) - OQ_CW'(pop);
    end
  end

endmodule

`default_nettype wire

/* hdl/pcrla_back.sv */
// ----------------------------------------------------------------------------
// pcrla_back
// Execution pipeline: multiply, reduce, accumulate, shift, round/saturate and
// activation table access. Never stalls; takes a result request only when a
// result queue slot is free to be reserved for it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrla_back #(
  parameter int LANES = pcrla_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                mq_valid,
  input  wire pcrla_pkg::mq_item_t                 mq_item,
  output logic                                     mq_pop,
  input  wire logic [pcrla_pkg::SHIFT_W-1:0]       rq_shift,
  input  wire pcrla_pkg::oq_stat_t                 oq_stat,
  output logic                                     res_push,
  output logic signed [pcrla_pkg::VAL_W-1:0]       res_value,
  output logic signed [pcrla_pkg::VAL_W-1:0]       res_rq
);

  import pcrla_pkg::*;

  `include "pointwise_conv_requant_lut_act_assert.svh"

  // lanes past the 64-bit fields contribute nothing
  localparam int NL     = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int PROD_W = 2 * LANE_W;
  localparam int PSUM_W = PROD_W + $clog2(NL);

  typedef struct packed {
    item_kind_t               kind;
    logic                     first;
    logic signed [BIAS_W-1:0] bias;
    logic [LUT_AW-1:0]        lut_index;
    logic signed [VAL_W-1:0]  lut_value;
  } stage_t;

  logic                     take, take_res;
  logic [OQ_CW-1:0]         reserved_r;

  logic signed [PROD_W-1:0] prod_nxt [NL];
  logic signed [PROD_W-1:0] prod_r   [NL];
  logic signed [PSUM_W-1:0] psum_nxt, psum_r;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  qf_nxt, qf_r;
  logic                     guard_nxt, guard_r, sticky_nxt, sticky_r, szero_r;
  logic [SHIFT_W-1:0]       sm1;
  logic [ACC_W-1:0]         lo_mask;
  logic signed [ACC_W:0]    qr;
  logic signed [VAL_W-1:0]  rq_nxt, rq5_r;
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  stage_t                   st0, st1_r, st2_r, st3_r, st4_r;
  logic                     ram_we, ram_re;
  logic [VAL_W-1:0]         ram_rdata;

  // result requests need a free result queue slot (queued + in flight)
  assign take_res = (mq_item.kind == KIND_ACC_LAST);
  assign take     = mq_valid && (!take_res || (reserved_r < OQ_CW'(OQ_DEPTH)));
  assign mq_pop   = take;

  always_comb begin
    st0.kind      = mq_item.kind;
    st0.first     = mq_item.first;
    st0.bias      = mq_item.bias;
    st0.lut_index = mq_item.lut_index;
    st0.lut_value = mq_item.lut_value;
  end

  // stage 1: lane products
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      prod_nxt[k] = $signed(mq_item.act_lanes[LANE_W*k +: LANE_W]) *
                    $signed(mq_item.wt_lanes[LANE_W*k +: LANE_W]);
    end
  end

  // stage 2: reduce
  always_comb begin
    psum_nxt = '0;
    for (int k = 0; k < NL; k++) begin
      psum_nxt = psum_nxt + PSUM_W'(prod_r[k]);
    end
  end

  // stage 3: accumulate, wraps at 32 bits
  always_comb begin
    acc_nxt = (st2_r.first ? st2_r.bias : acc_r) + ACC_W'(psum_r);
  end

  // stage 4: floor shift, guard and sticky bits
  always_comb begin
    sm1        = rq_shift - SHIFT_W'(1);
    lo_mask    = (ACC_W'(1) << sm1) - ACC_W'(1);
    qf_nxt     = $signed(acc_r) >>> rq_shift;
    guard_nxt  = (rq_shift != '0) && acc_r[sm1];
    sticky_nxt = |(acc_r & lo_mask);
  end

  // stage 5: round half to even, saturate
  always_comb begin
    qr = {qf_r[ACC_W-1], qf_r} +
         (ACC_W+1)'(!szero_r && guard_r && (sticky_r || qf_r[0]));
    if (qr > (ACC_W+1)'(RQ_MAX)) begin
      rq_nxt = VAL_W'(RQ_MAX);
    end else if (qr < (ACC_W+1)'(RQ_MIN)) begin
      rq_nxt = VAL_W'(RQ_MIN);
    end else begin
      rq_nxt = VAL_W'(qr);
    end
  end

  assign ram_we = v4_r && (st4_r.kind == KIND_LUT_WR);
  assign ram_re = v4_r && (st4_r.kind == KIND_ACC_LAST);

  pcrla_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LUT_DEPTH)
  ) u_lut (
    .clk   (clk),
    .we    (ram_we),
    .waddr (st4_r.lut_index),
    .wdata (st4_r.lut_value),
    .re    (ram_re),
    .raddr (rq_nxt + LUT_OFFSET),
    .rdata (ram_rdata)
  );

  assign res_push  = v5_r;
  assign res_value = ram_rdata;
  assign res_rq    = rq5_r;

  // datapath registers
  always_ff @(posedge clk) begin
    st1_r    <= st0;
    prod_r   <= prod_nxt;
    st2_r    <= st1_r;
    psum_r   <= psum_nxt;
    st3_r    <= st2_r;
    st4_r    <= st3_r;
    qf_r     <= qf_nxt;
    guard_r  <= guard_nxt;
    sticky_r <= sticky_nxt;
    szero_r  <= (rq_shift == '0);
    rq5_r    <= rq_nxt;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      acc_r      <= '0;
      reserved_r <= '0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= ram_re;
      if (v2_r && (st2_r.kind != KIND_LUT_WR)) begin
        acc_r <= acc_nxt;
      end
      reserved_r <= reserved_r + OQ_CW'(take && take_res) - OQ_CW'(oq_stat.pop);
    end
  end

  `PCRLA_ASSERT_IMP(a_push_has_room, v5_r, !oq_stat.full)
  `PCRLA_ASSERT_IMP(a_reserve_covers_queue, 1'b1, reserved_r >= oq_stat.count)
  `PCRLA_ASSERT_NXT(a_lut_wr_keeps_acc, v2_r && (st2_r.kind == KIND_LUT_WR),
                    acc_r == $past(acc_r))

endmodule

`default_nettype wire

/* hdl/pointwise_conv_requant_lut_act.sv */
// ----------------------------------------------------------------------------
// pointwise_conv_requant_lut_act
// int8 1x1 convolution with requantization and activation table lookup.
// ----------------------------------------------------------------------------
// - Input (in_push / in_full): one request per edge with push high, full low.
//   cmd 0 writes in_lut_value at table entry in_lut_index; cmd 1 adds up to eight
//   int8 act*wt products to the 32-bit accumulator (in_bias loaded first
//   when in_first is set). cmd 1 with in_last queues one result:
//   out_requantized = sat8(round_half_even(acc >> rq_shift)),
//   out_value = table[out_requantized + 128].
// - Results (out_empty / out_pop): oldest result on the ports while
//   out_empty is low; it leaves at an edge with out_pop high.
// - Config: APB write of rq_shift at byte address 0, only while idle.
// - Throughput: one request per cycle while no result request waits for a
//   result queue slot (one table access per cycle).
// - Receiver stall: results collect in an 8-deep queue; a result request
//   waits at the back end while all slots are reserved, the 4-deep front
//   queue fills and in_full rises. Nothing is dropped.
// - Reset (rst_n low, sync): queues empty, accumulator and rq_shift 0;
//   table contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pointwise_conv_requant_lut_act #(
  parameter int LANES = pcrla_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_push,
  output logic                                     in_full,
  input  wire logic                                in_cmd,
  input  wire logic [pcrla_pkg::LANES_W-1:0]       in_act_lanes,
  input  wire logic [pcrla_pkg::LANES_W-1:0]       in_wt_lanes,
  input  wire logic signed [pcrla_pkg::BIAS_W-1:0] in_bias,
  input  wire logic                                in_first,
  input  wire logic                                in_last,
  input  wire logic [pcrla_pkg::LUT_AW-1:0]        in_lut_index,
  input  wire logic signed [pcrla_pkg::VAL_W-1:0]  in_lut_value,
  // result channel
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output logic signed [pcrla_pkg::VAL_W-1:0]       out_value,
  output logic signed [pcrla_pkg::VAL_W-1:0]       out_requantized,
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [pcrla_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [pcrla_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [pcrla_pkg::CFG_DW-1:0]             cfg_prdata,
  output logic                                     cfg_pready
);

  import pcrla_pkg::*;

  logic                    mq_valid, mq_pop;
  mq_item_t                mq_item;
  oq_stat_t                oq_stat;
  logic                    res_push;
  logic signed [VAL_W-1:0] res_value, res_rq;
  logic [SHIFT_W-1:0]      shift_r;
  logic                    cfg_wr;
  logic [CFG_AW-3:0]       cfg_reg;

  // Config register: word address selects the register, byte bits ignored.
  assign cfg_pready = 1'b1;
  assign cfg_reg    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_reg == REG_RQ_SHIFT) begin
      cfg_prdata = {{(CFG_DW-SHIFT_W){1'b0}}, shift_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_wr && (cfg_reg == REG_RQ_SHIFT)) begin
      shift_r <= cfg_pwdata[SHIFT_W-1:0];
    end
  end

  // Front: take and tag requests, short queue toward the back end.
  pcrla_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_act_lanes (in_act_lanes),
    .in_wt_lanes  (in_wt_lanes),
    .in_bias      (in_bias),
    .in_first     (in_first),
    .in_last      (in_last),
    .in_lut_index (in_lut_index),
    .in_lut_value (in_lut_value),
    .mq_valid     (mq_valid),
    .mq_item      (mq_item),
    .mq_pop       (mq_pop)
  );

  // Back: MAC, requantize and table pipeline.
  pcrla_back #(
    .LANES (LANES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mq_valid    (mq_valid),
    .mq_item     (mq_item),
    .mq_pop      (mq_pop),
    .rq_shift    (shift_r),
    .oq_stat     (oq_stat),
    .res_push    (res_push),
    .res_value   (res_value),
    .res_rq      (res_rq)
  );

  // Result queue: decouples the pipeline from the receiver.
  pcrla_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (res_push),
    .push_value      (res_value),
    .push_rq         (res_rq),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_value       (out_value),
    .out_requantized (out_requantized),
    .stat            (oq_stat)
  );

endmodule

`default_nettype wire
